@@ hdl/u8d_pkg.sv @@
// Shared types, constants and the lead-byte decode function of the UTF-8 BMP decoder.
package u8d_pkg;

   localparam logic [15:0] REPLACEMENT    = 16'hFFFD;
   localparam logic [15:0] MIN_TWO_BYTE   = 16'h0080;
   localparam logic [15:0] MIN_THREE_BYTE = 16'h0800;

   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      PH_IDLE         = 3'd0,
      PH_TWO_LAST     = 3'd1,
      PH_THREE_SECOND = 3'd2,
      PH_THREE_LAST   = 3'd3,
      PH_SKIP         = 3'd4
   } phase_type;

   typedef struct packed {
      logic [15:0] code_point;
      logic        has_char;
      logic        stream_end;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } result_pair_type;

   typedef struct packed {
      logic        emit;
      logic [15:0] code_point;
      phase_type   phase;
      logic [15:0] partial;
   } fresh_type;

   // Byte seen with no sequence pending.
   function automatic fresh_type fresh_byte(input logic [7:0] b);
      fresh_type f;
      f.emit       = 1'b0;
      f.code_point = 16'h0000;
      f.phase      = PH_IDLE;
      f.partial    = 16'h0000;
      case (b) inside
         [8'h00:8'h7F]: begin
            f.emit       = 1'b1;
            f.code_point = {8'h00, b};
         end
         [8'h80:8'hBF]: begin
            f.emit       = 1'b1;
            f.code_point = REPLACEMENT;
         end
         [8'hC0:8'hDF]: begin
            f.phase   = PH_TWO_LAST;
            f.partial = {5'b0, b[4:0], 6'b0};
         end
         [8'hE0:8'hEF]: begin
            f.phase   = PH_THREE_SECOND;
            f.partial = {b[3:0], 12'b0};
         end
         default: begin
            f.emit       = 1'b1;
            f.code_point = REPLACEMENT;
            f.phase      = PH_SKIP;
         end
      endcase
      return f;
   endfunction

endpackage

@@ hdl/u8d_decode.sv @@
// Per-byte decode: sequence state registers and the logic that forms up to two results.
module u8d_decode (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_accept,
   input  logic [7:0]                 data_byte,
   input  logic                       end_of_stream,
   output u8d_pkg::result_pair_type   results
);

   u8d_pkg::phase_type phase_ff, phase_in;
   logic [15:0]        partial_ff, partial_in;

   u8d_pkg::fresh_type fr;
   logic               cont;
   logic [15:0]        joined;
   logic [15:0]        limit;
   logic [1:0]         n;
   logic [15:0]        q0, q1;
   logic               marker;

   always_comb begin
      fr         = u8d_pkg::fresh_byte(data_byte);
      cont       = (data_byte[7:6] == 2'b10);
      joined     = partial_ff | {10'b0, data_byte[5:0]};
      limit      = (phase_ff == u8d_pkg::PH_TWO_LAST) ? u8d_pkg::MIN_TWO_BYTE
                                                      : u8d_pkg::MIN_THREE_BYTE;
      n          = 2'd0;
      q0         = 16'h0000;
      q1         = 16'h0000;
      marker     = 1'b0;
      phase_in   = phase_ff;
      partial_in = partial_ff;

      case (phase_ff)
         u8d_pkg::PH_TWO_LAST, u8d_pkg::PH_THREE_LAST: begin
            if (cont) begin
               q0         = (joined < limit) ? u8d_pkg::REPLACEMENT : joined;
               n          = 2'd1;
               phase_in   = u8d_pkg::PH_IDLE;
               partial_in = 16'h0000;
            end else begin
               q0         = u8d_pkg::REPLACEMENT;
               q1         = fr.code_point;
               n          = fr.emit ? 2'd2 : 2'd1;
               phase_in   = fr.phase;
               partial_in = fr.partial;
            end
         end
         u8d_pkg::PH_THREE_SECOND: begin
            if (cont) begin
               partial_in = partial_ff | {4'b0, data_byte[5:0], 6'b0};
               phase_in   = u8d_pkg::PH_THREE_LAST;
            end else begin
               q0         = u8d_pkg::REPLACEMENT;
               q1         = fr.code_point;
               n          = fr.emit ? 2'd2 : 2'd1;
               phase_in   = fr.phase;
               partial_in = fr.partial;
            end
         end
         u8d_pkg::PH_SKIP: begin
            if (!cont) begin
               q0         = fr.code_point;
               n          = fr.emit ? 2'd1 : 2'd0;
               phase_in   = fr.phase;
               partial_in = fr.partial;
            end
         end
         default: begin
            q0         = fr.code_point;
            n          = fr.emit ? 2'd1 : 2'd0;
            phase_in   = fr.phase;
            partial_in = fr.partial;
         end
      endcase

      if (end_of_stream) begin
         if (phase_in == u8d_pkg::PH_TWO_LAST || phase_in == u8d_pkg::PH_THREE_SECOND ||
             phase_in == u8d_pkg::PH_THREE_LAST) begin
            if (n == 2'd0) begin
               q0 = u8d_pkg::REPLACEMENT;
               n  = 2'd1;
            end else begin
               q1 = u8d_pkg::REPLACEMENT;
               n  = 2'd2;
            end
         end
         if (n == 2'd0) begin
            q0     = 16'h0000;
            marker = 1'b1;
            n      = 2'd1;
         end
         phase_in   = u8d_pkg::PH_IDLE;
         partial_in = 16'h0000;
      end

      results.count             = n;
      results.first.code_point  = q0;
      results.first.has_char    = !marker;
      results.first.stream_end  = end_of_stream && (n == 2'd1);
      results.second.code_point = q1;
      results.second.has_char   = 1'b1;
      results.second.stream_end = end_of_stream && (n == 2'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= u8d_pkg::PH_IDLE;
         partial_ff <= 16'h0000;
      end else if (req_accept) begin
         phase_ff   <= phase_in;
         partial_ff <= partial_in;
      end
   end

   a_eos_returns_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept && end_of_stream |=> phase_ff == u8d_pkg::PH_IDLE && partial_ff == 16'h0000)
      else $error("state not cleared after end of stream");

   a_skip_drops_cont: assert property (@(posedge clock) disable iff (reset)
      req_accept && phase_ff == u8d_pkg::PH_SKIP && cont && !end_of_stream
      |-> results.count == 2'd0)
      else $error("continuation byte in skip produced a result");

   a_eos_has_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && end_of_stream
      |-> results.count != 2'd0 && (results.first.stream_end || results.second.stream_end))
      else $error("end of stream without a final result");

endmodule

@@ hdl/u8d_out_queue.sv @@
// Result queue: takes up to two results per cycle, delivers one per cycle while out_ready is high.
module u8d_out_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  u8d_pkg::result_pair_type   results,
   output logic                       room,
   output logic                       out_valid,
   input  logic                       out_ready,
   output u8d_pkg::result_type        out_result
);

   u8d_pkg::result_type                  entry_ff [u8d_pkg::QUEUE_DEPTH];
   logic [u8d_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [u8d_pkg::QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [u8d_pkg::QUEUE_COUNT_W-1:0]    count_ff, count_in;
   logic [1:0]                           push_count;
   logic                                 pop;
   logic [u8d_pkg::QUEUE_PTR_W-1:0]      wr_next;

   always_comb begin
      push_count = push ? results.count : 2'd0;
      pop        = out_valid && out_ready;
      wr_next    = wr_ptr_ff + u8d_pkg::QUEUE_PTR_W'(1);
      wr_ptr_in  = wr_ptr_ff + u8d_pkg::QUEUE_PTR_W'(push_count);
      rd_ptr_in  = rd_ptr_ff + u8d_pkg::QUEUE_PTR_W'(pop);
      count_in   = count_ff + u8d_pkg::QUEUE_COUNT_W'(push_count)
                            - u8d_pkg::QUEUE_COUNT_W'(pop);
   end

   assign room       = (count_ff <= u8d_pkg::QUEUE_COUNT_W'(u8d_pkg::QUEUE_DEPTH - 2));
   assign out_valid  = (count_ff != '0);
   assign out_result = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= results.first;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_next] <= results.second;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_count != 2'd0
      |-> count_ff + u8d_pkg::QUEUE_COUNT_W'(push_count)
          <= u8d_pkg::QUEUE_COUNT_W'(u8d_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= u8d_pkg::QUEUE_COUNT_W'(u8d_pkg::QUEUE_DEPTH))
      else $error("result queue count out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> count_ff == '0 && rd_ptr_ff == wr_ptr_ff)
      else $error("result queue not empty after reset");

endmodule

@@ hdl/utf8_bmp_stream_decoder.sv @@
// Top level of the UTF-8 to BMP stream decoder.
//
// Request channel (req_valid/req_ready): one raw UTF-8 byte per request,
// with req_end_of_stream set on the last byte of a stream.
// Response channel (rsp_valid/rsp_ready): one 16-bit code point per response;
// malformed input gives 0xFFFD, rsp_has_char is 0 only on a bare end marker,
// rsp_stream_end marks the final response of a stream.
// A byte gives zero, one or two responses; a stream end always gives at least one.
// Responses of a byte are registered in the result queue before they appear.
// Throughput: one byte per cycle while the receiver keeps up; a byte that
// gives two responses needs the response port twice, so the rate is
// set by the single response port draining a four-entry result queue.
// req_ready is high while the queue has room for two more responses, so
// bytes keep flowing while earlier responses wait. When the receiver stalls,
// the queue fills and req_ready drops; nothing is lost.
// Reset (synchronous, active high) empties the queue and returns the decoder
// to idle with no sequence pending.
module utf8_bmp_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_point,
   output logic        rsp_has_char,
   output logic        rsp_stream_end
);

   logic                      req_accept;
   u8d_pkg::result_pair_type  results;
   u8d_pkg::result_type       head;

   assign req_accept = req_valid && req_ready;

   u8d_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .req_accept    (req_accept),
      .data_byte     (req_data_byte),
      .end_of_stream (req_end_of_stream),
      .results       (results)
   );

   u8d_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .results    (results),
      .room       (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_result (head)
   );

   assign rsp_code_point = head.code_point;
   assign rsp_has_char   = head.has_char;
   assign rsp_stream_end = head.stream_end;

endmodule
